// File: hw/rtl/plsc_pkg.sv
// Package: constants, codes and controller/datapath interface types of the slot cache.
`timescale 1ns / 1ps
package plsc_pkg;

  localparam int unsigned NumSlots   = 32;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned CntW       = 6;
  localparam int unsigned IdW        = 8;
  localparam int unsigned LimW       = 9;
  localparam int unsigned StampW     = 31;
  localparam int unsigned PhaseW     = 4;
  localparam int unsigned StatW      = 32;
  localparam int unsigned MaxExperts = 256;

  localparam logic [1:0] OpAccess   = 2'd0;
  localparam logic [1:0] OpPrefetch = 2'd1;
  localparam logic [1:0] OpRelease  = 2'd2;
  localparam logic [1:0] OpPin      = 2'd3;

  localparam logic [2:0] StHit     = 3'd0;
  localparam logic [2:0] StMiss    = 3'd1;
  localparam logic [2:0] StNoSlot  = 3'd2;
  localparam logic [2:0] StSkipped = 3'd3;
  localparam logic [2:0] StRelease = 3'd4;
  localparam logic [2:0] StRefused = 3'd5;

  localparam logic RegSlotsInUse = 1'b0;
  localparam logic RegExperts    = 1'b1;

  localparam logic [PhaseW-1:0] PhaseShared = 4'hF;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } plsc_cmd_t;

  typedef struct packed {
    logic scan_last;
  } plsc_sts_t;

endpackage

// File: hw/rtl/plsc_ctrl.sv
// Controller: sequences load, slot scan and update for one transaction.
`timescale 1ns / 1ps
module plsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  plsc_pkg::plsc_sts_t sts_i,
  output plsc_pkg::plsc_cmd_t cmd_o,
  output logic               busy_o
);
  import plsc_pkg::*;

  localparam logic [1:0] SIdle   = 2'd0;
  localparam logic [1:0] SScan   = 2'd1;
  localparam logic [1:0] SUpdate = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = SScan;
        end
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = SUpdate;
      end
      SUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else         state_q <= state_d;
  end
endmodule

// File: hw/rtl/plsc_dp.sv
// Datapath: slot store, scan accumulators, update logic, counters and result registers.
`timescale 1ns / 1ps
module plsc_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  plsc_pkg::plsc_cmd_t          cmd_i,
  output plsc_pkg::plsc_sts_t          sts_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [plsc_pkg::LimW-1:0]    cfg_wdata_i,
  input  logic [1:0]                   operation_i,
  input  logic [plsc_pkg::IdW-1:0]     req_id_i,
  input  logic [plsc_pkg::SlotW-1:0]   slot_index_i,
  input  logic [plsc_pkg::PhaseW-1:0]  phase_code_i,
  input  logic                         last_in_batch_i,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic [plsc_pkg::SlotW-1:0]   slot_o,
  output logic                         fill_needed_o,
  output logic                         evicted_o,
  output logic [plsc_pkg::IdW-1:0]     evicted_expert_o,
  output logic [plsc_pkg::CntW-1:0]    slots_filled_o,
  output logic [plsc_pkg::StatW-1:0]   access_cnt_o,
  output logic [plsc_pkg::StatW-1:0]   hit_cnt_o,
  output logic [plsc_pkg::StatW-1:0]   miss_cnt_o,
  output logic [plsc_pkg::StatW-1:0]   evict_cnt_o
);
  import plsc_pkg::*;

  // configuration
  logic [CntW-1:0] slots_cfg_q;
  logic [LimW-1:0] experts_cfg_q;

  // slot store
  logic              valid_q  [NumSlots];
  logic              locked_q [NumSlots];
  logic [IdW-1:0]    tag_q    [NumSlots];
  logic [StampW-1:0] stamp_q  [NumSlots];
  logic [PhaseW-1:0] phase_q  [NumSlots];

  logic [StampW-1:0] use_clock_q;
  logic [CntW-1:0]   pin_next_q;
  logic              batch_stop_q;
  logic [StatW-1:0]  req_q, hit_q, miss_q, evc_q;

  // latched transaction
  logic [1:0]        op_q;
  logic [IdW-1:0]    id_q;
  logic [SlotW-1:0]  si_q;
  logic [PhaseW-1:0] ph_q;
  logic              last_q;
  logic [CntW-1:0]   n_q;
  logic              in_range_q;

  // scan accumulators
  logic [SlotW-1:0]  idx_q;
  logic [CntW-1:0]   occ_q;
  logic              hit_fnd_q, vic_fnd_q, vic_free_q, dup_q;
  logic              si_seen_q, si_lock_q, si_valid_q, pin_valid_q;
  logic [SlotW-1:0]  hit_idx_q, vic_idx_q;
  logic [StampW-1:0] vic_stamp_q;
  logic [IdW-1:0]    vic_tag_q;

  logic [CntW-1:0]   n_d;
  logic [LimW-1:0]   lim_d;
  logic              cur_v, cur_l, tag_eq, take_vic;
  logic [StampW-1:0] new_stamp;

  always_comb begin
    if (slots_cfg_q == '0)                          n_d = CntW'(1);
    else if (slots_cfg_q > CntW'(NumSlots))         n_d = CntW'(NumSlots);
    else                                            n_d = slots_cfg_q;
    if (experts_cfg_q > LimW'(MaxExperts))          lim_d = LimW'(MaxExperts);
    else                                            lim_d = experts_cfg_q;
  end

  assign cur_v    = valid_q[idx_q];
  assign cur_l    = locked_q[idx_q];
  assign tag_eq   = (tag_q[idx_q] == id_q);
  assign take_vic = !cur_l && !vic_free_q &&
                    (!cur_v || !vic_fnd_q || (stamp_q[idx_q] < vic_stamp_q));
  assign new_stamp = use_clock_q + StampW'(1);
  assign sts_o.scan_last = ({1'b0, idx_q} == (n_q - CntW'(1)));

  // update decisions
  logic do_hit, do_alloc, do_evict, do_release, do_pin;
  logic [2:0]       st_d;
  logic [SlotW-1:0] slot_d;
  logic [CntW-1:0]  occ_d;
  logic             stop_d;

  always_comb begin
    do_hit = 1'b0; do_alloc = 1'b0; do_evict = 1'b0;
    do_release = 1'b0; do_pin = 1'b0;
    st_d = StSkipped; slot_d = '0; occ_d = occ_q;
    stop_d = batch_stop_q;
    case (op_q)
      OpAccess: begin
        stop_d = 1'b0;
        if (hit_fnd_q) begin
          do_hit = 1'b1; st_d = StHit; slot_d = hit_idx_q;
        end else if (vic_fnd_q) begin
          do_alloc = 1'b1; st_d = StMiss; slot_d = vic_idx_q;
        end else begin
          st_d = StNoSlot;
        end
      end
      OpPrefetch: begin
        if (!batch_stop_q && in_range_q && !hit_fnd_q) begin
          if (vic_fnd_q) begin
            do_alloc = 1'b1; st_d = StMiss; slot_d = vic_idx_q;
          end else begin
            st_d = StNoSlot; stop_d = 1'b1;
          end
        end
        if (last_q) stop_d = 1'b0;
      end
      OpRelease: begin
        stop_d = 1'b0;
        if (!si_seen_q || si_lock_q) begin
          st_d = StRefused;
        end else begin
          do_release = 1'b1; st_d = StRelease; slot_d = si_q;
          if (si_valid_q) occ_d = occ_q - CntW'(1);
        end
      end
      default: begin
        stop_d = 1'b0;
        if (!in_range_q || dup_q) begin
          st_d = StSkipped;
        end else if (pin_next_q >= n_q) begin
          st_d = StNoSlot;
        end else begin
          do_pin = 1'b1; st_d = StMiss; slot_d = pin_next_q[SlotW-1:0];
          if (!pin_valid_q) occ_d = occ_q + CntW'(1);
        end
      end
    endcase
    if (do_alloc) begin
      do_evict = !vic_free_q;
      if (vic_free_q) occ_d = occ_q + CntW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_cfg_q   <= CntW'(NumSlots);
      experts_cfg_q <= LimW'(MaxExperts);
      use_clock_q   <= '0;
      pin_next_q    <= '0;
      batch_stop_q  <= 1'b0;
      req_q <= '0; hit_q <= '0; miss_q <= '0; evc_q <= '0;
      done_o        <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        valid_q[i]  <= 1'b0;
        locked_q[i] <= 1'b0;
        tag_q[i]    <= '0;
        stamp_q[i]  <= '0;
        phase_q[i]  <= '0;
      end
    end else begin
      done_o <= cmd_i.update;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegSlotsInUse) slots_cfg_q   <= cfg_wdata_i[CntW-1:0];
        else                            experts_cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.update) begin
        batch_stop_q <= stop_d;
        if (op_q == OpAccess) begin
          req_q <= req_q + StatW'(1);
          if (hit_fnd_q) hit_q  <= hit_q + StatW'(1);
          else           miss_q <= miss_q + StatW'(1);
        end
        if (do_evict) evc_q <= evc_q + StatW'(1);
        if (do_hit || do_alloc || do_pin) use_clock_q <= new_stamp;
        if (do_hit) stamp_q[hit_idx_q] <= new_stamp;
        if (do_alloc) begin
          valid_q[vic_idx_q] <= 1'b1;
          tag_q[vic_idx_q]   <= id_q;
          stamp_q[vic_idx_q] <= new_stamp;
          phase_q[vic_idx_q] <= ph_q;
        end
        if (do_release) begin
          valid_q[si_q] <= 1'b0;
          tag_q[si_q]   <= '0;
          stamp_q[si_q] <= '0;
          phase_q[si_q] <= '0;
        end
        if (do_pin) begin
          valid_q[pin_next_q[SlotW-1:0]]  <= 1'b1;
          locked_q[pin_next_q[SlotW-1:0]] <= 1'b1;
          tag_q[pin_next_q[SlotW-1:0]]    <= id_q;
          stamp_q[pin_next_q[SlotW-1:0]]  <= new_stamp;
          phase_q[pin_next_q[SlotW-1:0]]  <= PhaseShared;
          pin_next_q <= pin_next_q + CntW'(1);
        end
      end
    end
  end

  // transaction latch, scan accumulators and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i; id_q <= req_id_i; si_q <= slot_index_i;
      ph_q <= phase_code_i; last_q <= last_in_batch_i;
      n_q <= n_d;
      in_range_q <= ({1'b0, req_id_i} < lim_d);
      idx_q <= '0; occ_q <= '0;
      hit_fnd_q <= 1'b0; vic_fnd_q <= 1'b0; vic_free_q <= 1'b0; dup_q <= 1'b0;
      si_seen_q <= 1'b0; si_lock_q <= 1'b0; si_valid_q <= 1'b0; pin_valid_q <= 1'b0;
      hit_idx_q <= '0; vic_idx_q <= '0; vic_stamp_q <= '0; vic_tag_q <= '0;
    end
    if (cmd_i.scan) begin
      idx_q <= idx_q + SlotW'(1);
      if (cur_v) occ_q <= occ_q + CntW'(1);
      if (cur_v && tag_eq && !hit_fnd_q) begin
        hit_fnd_q <= 1'b1; hit_idx_q <= idx_q;
      end
      if (take_vic) begin
        vic_fnd_q <= 1'b1; vic_idx_q <= idx_q;
        vic_free_q  <= !cur_v;
        vic_stamp_q <= stamp_q[idx_q];
        vic_tag_q   <= tag_q[idx_q];
      end
      if (cur_l && cur_v && tag_eq && ({1'b0, idx_q} < pin_next_q)) dup_q <= 1'b1;
      if (idx_q == si_q) begin
        si_seen_q <= 1'b1; si_lock_q <= cur_l; si_valid_q <= cur_v;
      end
      if ({1'b0, idx_q} == pin_next_q) pin_valid_q <= cur_v;
    end
    if (cmd_i.update) begin
      status_o         <= st_d;
      slot_o           <= slot_d;
      fill_needed_o    <= do_alloc || do_pin;
      evicted_o        <= do_evict;
      evicted_expert_o <= do_evict ? vic_tag_q : '0;
      slots_filled_o   <= occ_d;
      access_cnt_o     <= (op_q == OpAccess) ? req_q + StatW'(1) : req_q;
      hit_cnt_o        <= (op_q == OpAccess && hit_fnd_q) ? hit_q + StatW'(1) : hit_q;
      miss_cnt_o       <= (op_q == OpAccess && !hit_fnd_q) ? miss_q + StatW'(1) : miss_q;
      evict_cnt_o      <= do_evict ? evc_q + StatW'(1) : evc_q;
    end
  end
endmodule

// File: hw/rtl/pinned_lru_slot_cache.sv
// Top level of the pinned LRU slot cache: controller plus datapath.
//
// Usage:
//  - Command channel: a transaction is taken at a rising edge with start_i high
//    and busy_o low. Fields: operation (access, prefetch, release, pin),
//    req_id, slot_index, phase_code, last_in_batch.
//  - Result channel: done_o pulses for one cycle with status, slot, fill and
//    eviction info, occupancy and the four wrapping statistic counters.
//    The receiver cannot stall; results must be captured on the strobe.
//  - Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (0 slots in use, 1 experts per layer); only while busy_o is low.
//  - Sequence: n = effective slots in use (1..32). A load, a scan of the n
//    slots (one slot compared per cycle for hit, victim, occupancy and
//    pin duplicate), an update, then the result strobe in the next cycle.
//    A new command may be issued in the strobe cycle; none is taken while
//    busy_o is high.
//  - Reset: all slots empty and unpinned, counters and use clock zero,
//    registers back to 32 slots and 256 experts. No clearing pass needed.
`timescale 1ns / 1ps
module pinned_lru_slot_cache (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [plsc_pkg::LimW-1:0]    cfg_wdata_i,
  input  logic [1:0]                   operation_i,
  input  logic [plsc_pkg::IdW-1:0]     req_id_i,
  input  logic [plsc_pkg::SlotW-1:0]   slot_index_i,
  input  logic [plsc_pkg::PhaseW-1:0]  phase_code_i,
  input  logic                         last_in_batch_i,
  output logic                         done_o,
  output logic [2:0]                   status_o,
  output logic [plsc_pkg::SlotW-1:0]   slot_o,
  output logic                         fill_needed_o,
  output logic                         evicted_o,
  output logic [plsc_pkg::IdW-1:0]     evicted_expert_o,
  output logic [plsc_pkg::CntW-1:0]    slots_filled_o,
  output logic [plsc_pkg::StatW-1:0]   access_cnt_o,
  output logic [plsc_pkg::StatW-1:0]   hit_cnt_o,
  output logic [plsc_pkg::StatW-1:0]   miss_cnt_o,
  output logic [plsc_pkg::StatW-1:0]   evict_cnt_o
);
  import plsc_pkg::*;

  plsc_cmd_t cmd;
  plsc_sts_t sts;

  // sequencing: idle -> scan -> update
  plsc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // slot store, scan logic and result registers
  plsc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operation_i      (operation_i),
    .req_id_i         (req_id_i),
    .slot_index_i     (slot_index_i),
    .phase_code_i     (phase_code_i),
    .last_in_batch_i  (last_in_batch_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .fill_needed_o    (fill_needed_o),
    .evicted_o        (evicted_o),
    .evicted_expert_o (evicted_expert_o),
    .slots_filled_o   (slots_filled_o),
    .access_cnt_o     (access_cnt_o),
    .hit_cnt_o        (hit_cnt_o),
    .miss_cnt_o       (miss_cnt_o),
    .evict_cnt_o      (evict_cnt_o)
  );
endmodule

// File: hw/rtl/plsc_checker.sv
// Port-level checker for the slot cache, bound to the top level.
`timescale 1ns / 1ps
module plsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [2:0] status_o,
  input logic       fill_needed_o,
  input logic       evicted_o
);
  import plsc_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted command did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o)) else $error("result strobe out of sequence");

  a_fill_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && fill_needed_o |-> status_o == StMiss) else $error("fill without allocation");

  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> fill_needed_o) else $error("eviction without fill");
endmodule

bind pinned_lru_slot_cache plsc_checker u_plsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .fill_needed_o (fill_needed_o),
  .evicted_o     (evicted_o)
);

// File: sim/testbench.sv
// Testbench for the pinned LRU slot cache: directed table plus random traffic vs. a predictor.
`timescale 1ns / 1ps
module testbench;
  import plsc_pkg::*;

  // Run limit: ~1950 transactions plus long idle gaps, with margin.
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandItems  = 1950;

  typedef struct packed {
    logic [2:0]        status;
    logic [SlotW-1:0]  slot;
    logic              fill;
    logic              evicted;
    logic [IdW-1:0]    evicted_id;
    logic [CntW-1:0]   occupied;
    logic [StatW-1:0]  requests;
    logic [StatW-1:0]  hits;
    logic [StatW-1:0]  misses;
    logic [StatW-1:0]  evictions;
  } cache_result_t;

  // One row of the directed table. A config row writes both registers and sends nothing.
  typedef struct {
    bit                is_cfg;
    logic [LimW-1:0]   cfg_slots;
    logic [LimW-1:0]   cfg_experts;
    logic [1:0]        op;
    logic [IdW-1:0]    id;
    logic [SlotW-1:0]  sidx;
    logic [PhaseW-1:0] phase;
    logic              last;
    bit                typed;
    logic [2:0]        st;
    logic [SlotW-1:0]  slot;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [LimW-1:0]   cfg_wdata_i = '0;
  logic [1:0]        operation_i = OpAccess;
  logic [IdW-1:0]    req_id_i = '0;
  logic [SlotW-1:0]  slot_index_i = '0;
  logic [PhaseW-1:0] phase_code_i = '0;
  logic              last_in_batch_i = 1'b0;
  logic              done_o;
  logic [2:0]        status_o;
  logic [SlotW-1:0]  slot_o;
  logic              fill_needed_o;
  logic              evicted_o;
  logic [IdW-1:0]    evicted_expert_o;
  logic [CntW-1:0]   slots_filled_o;
  logic [StatW-1:0]  access_cnt_o;
  logic [StatW-1:0]  hit_cnt_o;
  logic [StatW-1:0]  miss_cnt_o;
  logic [StatW-1:0]  evict_cnt_o;

  pinned_lru_slot_cache dut (.*);

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache state, used to predict every result.
  // ---------------------------------------------------------------------------
  bit               sh_valid  [NumSlots];
  logic [IdW-1:0]   sh_tag    [NumSlots];
  bit               sh_locked [NumSlots];
  logic [StampW-1:0] sh_stamp [NumSlots];
  logic [StatW-1:0] sh_hits   [NumSlots];
  logic [PhaseW-1:0] sh_phase [NumSlots];
  logic [StampW-1:0] use_clk;
  logic [CntW-1:0]  pin_ptr;
  bit               batch_halted;
  logic [StatW-1:0] n_requests, n_hits, n_misses, n_evictions;
  logic [CntW-1:0]  reg_slots;
  logic [LimW-1:0]  reg_experts;

  cache_result_t expected_q[$];
  int unsigned   cycles = 0;
  int unsigned   errors;
  int unsigned   sent;

  function automatic void wipe_slot(int i);
    sh_valid[i] = 1'b0;
    sh_tag[i]   = '0;
    sh_phase[i] = '0;
    sh_hits[i]  = '0;
    sh_stamp[i] = '0;
  endfunction

  function automatic void load_slot(int s, logic [IdW-1:0] id);
    use_clk     = use_clk + 1'b1;   // 31-bit, wraps
    sh_valid[s] = 1'b1;
    sh_tag[s]   = id;
    sh_hits[s]  = StatW'(1);
    sh_stamp[s] = use_clk;
  endfunction

  function automatic int find_id(logic [IdW-1:0] id, int n);
    for (int i = 0; i < n; i++)
      if (sh_valid[i] && sh_tag[i] == id) return i;
    return -1;
  endfunction

  // First free unpinned slot, else oldest unpinned valid slot (lowest index on ties).
  function automatic int pick_victim(int n, logic [PhaseW-1:0] ph, ref cache_result_t r);
    int v;
    v = -1;
    for (int i = 0; i < n; i++) begin
      if (sh_locked[i]) continue;
      if (!sh_valid[i]) begin
        v = i;
        break;
      end
      if (v < 0 || sh_stamp[i] < sh_stamp[v]) v = i;
    end
    if (v < 0) return -1;
    if (sh_valid[v]) begin
      r.evicted    = 1'b1;
      r.evicted_id = sh_tag[v];
      n_evictions++;
    end
    wipe_slot(v);
    sh_phase[v] = ph;
    return v;
  endfunction

  function automatic cache_result_t predict_lookup(logic [1:0] op, logic [IdW-1:0] id,
                                                   logic [SlotW-1:0] sidx,
                                                   logic [PhaseW-1:0] ph, logic last);
    cache_result_t r;
    int n, lim, s, occ;
    bit dup;
    r = '0;
    r.status = StSkipped;
    n   = (reg_slots == 0) ? 1 : (reg_slots > NumSlots ? NumSlots : reg_slots);
    lim = (reg_experts > MaxExperts) ? MaxExperts : reg_experts;
    if (op != OpPrefetch) batch_halted = 1'b0;
    case (op)
      OpAccess: begin
        n_requests++;
        s = find_id(id, n);
        if (s >= 0) begin
          n_hits++;
          sh_hits[s]++;
          use_clk     = use_clk + 1'b1;
          sh_stamp[s] = use_clk;
          r.status = StHit;
          r.slot   = SlotW'(s);
        end else begin
          n_misses++;
          s = pick_victim(n, ph, r);
          if (s < 0) r.status = StNoSlot;
          else begin
            load_slot(s, id);
            r.status = StMiss;
            r.slot   = SlotW'(s);
            r.fill   = 1'b1;
          end
        end
      end
      OpPrefetch: begin
        if (!batch_halted && id < lim && find_id(id, n) < 0) begin
          s = pick_victim(n, ph, r);
          if (s < 0) begin
            r.status     = StNoSlot;
            batch_halted = 1'b1;
          end else begin
            load_slot(s, id);
            r.status = StMiss;
            r.slot   = SlotW'(s);
            r.fill   = 1'b1;
          end
        end
        if (last) batch_halted = 1'b0;
      end
      OpRelease: begin
        if (sidx >= n || sh_locked[sidx]) r.status = StRefused;
        else begin
          wipe_slot(sidx);
          r.status = StRelease;
          r.slot   = sidx;
        end
      end
      default: begin  // pin
        dup = 1'b0;
        for (int i = 0; i < n && i < pin_ptr; i++)
          if (sh_locked[i] && sh_valid[i] && sh_tag[i] == id) dup = 1'b1;
        if (id >= lim || dup) r.status = StSkipped;
        else if (pin_ptr >= n) r.status = StNoSlot;
        else begin
          s = pin_ptr;
          wipe_slot(s);
          sh_locked[s] = 1'b1;
          sh_phase[s]  = PhaseShared;
          load_slot(s, id);
          pin_ptr  = pin_ptr + 1'b1;
          r.status = StMiss;
          r.slot   = SlotW'(s);
          r.fill   = 1'b1;
        end
      end
    endcase
    occ = 0;
    for (int i = 0; i < n; i++) if (sh_valid[i]) occ++;
    r.occupied  = CntW'(occ);
    r.requests  = n_requests;
    r.hits      = n_hits;
    r.misses    = n_misses;
    r.evictions = n_evictions;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes short idles, rarely long ones.
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Drive one transaction at the falling edge and hold it until accepted.
  // Typed fields of a directed row replace the predicted ones.
  task automatic send(input logic [1:0] op, input logic [IdW-1:0] id,
                      input logic [SlotW-1:0] sidx, input logic [PhaseW-1:0] ph,
                      input logic last, input bit typed, input logic [2:0] st,
                      input logic [SlotW-1:0] sl);
    int gap;
    cache_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i         = 1'b1;
    operation_i     = op;
    req_id_i        = id;
    slot_index_i    = sidx;
    phase_code_i    = ph;
    last_in_batch_i = last;
    do @(posedge clk_i); while (busy_o);
    r = predict_lookup(op, id, sidx, ph, last);
    if (typed) begin
      r.status = st;
      r.slot   = sl;
    end
    expected_q.push_back(r);
    sent++;
  endtask

  // Registers change only with the cache idle and nothing in flight.
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [LimW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegSlotsInUse) reg_slots = data[CntW-1:0];
    else reg_experts = data;
  endtask

  task automatic set_config(input logic [LimW-1:0] slots, input logic [LimW-1:0] experts);
    drain();
    write_reg(RegSlotsInUse, slots);
    write_reg(RegExperts, experts);
  endtask

  // Directed table: reset behavior, every operation, range limits, pin rules,
  // prefetch batch stop, register extremes (slot counts 0 and all-ones act as clamped, as do all-ones experts).
  dir_row_t dir_rows[] = '{
    '{0, 0, 0, OpAccess,   8'd0,   5'd0,  4'd0,  1'b0, 1, StMiss,     5'd0},
    '{0, 0, 0, OpAccess,   8'd0,   5'd0,  4'd3,  1'b0, 1, StHit,      5'd0},
    '{0, 0, 0, OpAccess,   8'd255, 5'd0,  4'd15, 1'b1, 1, StMiss,     5'd1},
    '{0, 0, 0, OpPrefetch, 8'd255, 5'd0,  4'd0,  1'b1, 1, StSkipped,  5'd0},
    '{0, 0, 0, OpRelease,  8'd0,   5'd31, 4'd0,  1'b0, 1, StRelease,  5'd31},
    '{0, 0, 0, OpRelease,  8'd0,   5'd1,  4'd0,  1'b0, 1, StRelease,  5'd1},
    '{0, 0, 0, OpPin,      8'd7,   5'd0,  4'd0,  1'b0, 1, StMiss,     5'd0},
    '{0, 0, 0, OpPin,      8'd7,   5'd0,  4'd0,  1'b0, 1, StSkipped,  5'd0},
    '{0, 0, 0, OpRelease,  8'd0,   5'd0,  4'd0,  1'b0, 1, StRefused,  5'd0},
    '{0, 0, 0, OpAccess,   8'd7,   5'd0,  4'd0,  1'b0, 1, StHit,      5'd0},
    '{1, 9'd2, 9'd4, OpAccess, 8'd0, 5'd0, 4'd0, 1'b0, 0, StHit,      5'd0},
    '{0, 0, 0, OpPrefetch, 8'd200, 5'd0,  4'd0,  1'b0, 1, StSkipped,  5'd0},
    '{0, 0, 0, OpPin,      8'd3,   5'd0,  4'd0,  1'b0, 1, StMiss,     5'd1},
    '{0, 0, 0, OpPin,      8'd2,   5'd0,  4'd0,  1'b0, 1, StNoSlot,   5'd0},
    '{0, 0, 0, OpAccess,   8'd9,   5'd0,  4'd5,  1'b0, 1, StNoSlot,   5'd0},
    '{0, 0, 0, OpPrefetch, 8'd1,   5'd0,  4'd0,  1'b0, 1, StNoSlot,   5'd0},
    '{0, 0, 0, OpPrefetch, 8'd2,   5'd0,  4'd0,  1'b1, 1, StSkipped,  5'd0},
    '{0, 0, 0, OpPrefetch, 8'd1,   5'd0,  4'd0,  1'b1, 1, StNoSlot,   5'd0},
    '{0, 0, 0, OpRelease,  8'd0,   5'd5,  4'd0,  1'b0, 1, StRefused,  5'd0},
    '{1, 9'd0, 9'd0, OpAccess, 8'd0, 5'd0, 4'd0, 1'b0, 0, StHit,      5'd0},
    '{0, 0, 0, OpAccess,   8'd7,   5'd0,  4'd0,  1'b0, 1, StHit,      5'd0},
    '{0, 0, 0, OpPin,      8'd0,   5'd0,  4'd0,  1'b0, 1, StSkipped,  5'd0},
    '{1, 9'h1FF, 9'h1FF, OpAccess, 8'd0, 5'd0, 4'd0, 1'b0, 0, StHit,  5'd0},
    '{0, 0, 0, OpAccess,   8'd100, 5'd0,  4'd10, 1'b0, 0, StHit,      5'd0},
    '{0, 0, 0, OpPrefetch, 8'd255, 5'd0,  4'd9,  1'b1, 0, StHit,      5'd0}
  };

  // Random ID: mostly a small pool so hits and evictions are common.
  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return IdW'($urandom_range(0, 47));
    return IdW'($urandom_range(0, 255));
  endfunction

  logic [LimW-1:0] slot_choices[]   = '{1, 2, 5, 8, 16, 31, 32, 0, 63, 40};
  logic [LimW-1:0] expert_choices[] = '{1, 8, 16, 48, 256, 0, 511, 300};

  initial begin
    int blen, k;
    logic [LimW-1:0] s_val;
    bit broken;
    errors = 0;
    sent   = 0;
    for (int i = 0; i < NumSlots; i++) begin
      wipe_slot(i);
      sh_locked[i] = 1'b0;
    end
    use_clk      = '0;
    pin_ptr      = '0;
    batch_halted = 1'b0;
    {n_requests, n_hits, n_misses, n_evictions} = '0;
    reg_slots   = 6'd32;
    reg_experts = 9'd256;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_config(dir_rows[i].cfg_slots, dir_rows[i].cfg_experts);
      else send(dir_rows[i].op, dir_rows[i].id, dir_rows[i].sidx, dir_rows[i].phase,
                dir_rows[i].last, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].slot);
    end

    // Random phases, each under a new register setting. Upper bits of the
    // slot-count write are junk that the register drops.
    while (sent < RandItems) begin
      s_val = slot_choices[$urandom_range(0, slot_choices.size() - 1)];
      if ($urandom_range(0, 3) == 0) s_val[LimW-1:CntW] = 3'($urandom_range(0, 7));
      set_config(s_val, $urandom_range(0, 4) == 0 ? 9'($urandom)
                        : expert_choices[$urandom_range(0, expert_choices.size() - 1)]);
      for (int j = 0; j < 220 && sent < RandItems; ) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          send(OpAccess, pick_id(), 5'($urandom), 4'($urandom), 1'($urandom), 0, 0, 0);
          j++;
        end else if (k < 80) begin
          // Prefetch batch; now and then one that never marks its end.
          blen   = $urandom_range(1, 6);
          broken = ($urandom_range(0, 7) == 0);
          for (int b = 0; b < blen; b++)
            send(OpPrefetch, pick_id(), 5'($urandom), 4'($urandom),
                 (b == blen - 1) && !broken, 0, 0, 0);
          j += blen;
        end else if (k < 98) begin
          send(OpRelease, pick_id(), 5'($urandom), 4'($urandom), 1'($urandom), 0, 0, 0);
          j++;
        end else begin
          send(OpPin, pick_id(), 5'($urandom), 4'($urandom), 1'($urandom), 0, 0, 0);
          j++;
        end
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: every strobe is compared with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cache_result_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o); errors++;
        end
        if (slot_o !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, slot_o); errors++;
        end
        if (fill_needed_o !== e.fill) begin
          $error("fill_needed: expected %0d, got %0d", e.fill, fill_needed_o); errors++;
        end
        if (evicted_o !== e.evicted) begin
          $error("evicted: expected %0d, got %0d", e.evicted, evicted_o); errors++;
        end
        if (evicted_expert_o !== e.evicted_id) begin
          $error("evicted_expert: expected %0d, got %0d", e.evicted_id, evicted_expert_o);
          errors++;
        end
        if (slots_filled_o !== e.occupied) begin
          $error("slots_filled: expected %0d, got %0d", e.occupied, slots_filled_o);
          errors++;
        end
        if (access_cnt_o !== e.requests) begin
          $error("access_cnt: expected %0d, got %0d", e.requests, access_cnt_o);
          errors++;
        end
        if (hit_cnt_o !== e.hits) begin
          $error("hit_cnt: expected %0d, got %0d", e.hits, hit_cnt_o); errors++;
        end
        if (miss_cnt_o !== e.misses) begin
          $error("miss_cnt: expected %0d, got %0d", e.misses, miss_cnt_o); errors++;
        end
        if (evict_cnt_o !== e.evictions) begin
          $error("evict_cnt: expected %0d, got %0d", e.evictions, evict_cnt_o);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// File: sim.f
hw/rtl/plsc_pkg.sv
hw/rtl/plsc_ctrl.sv
hw/rtl/plsc_dp.sv
hw/rtl/pinned_lru_slot_cache.sv
hw/rtl/plsc_checker.sv
sim/testbench.sv
